/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* rtl/core/wrvc_pkg.sv */
// Package of types and constants for the velocity correction unit
package wrvc_pkg;
  localparam int DEF_MAX_TIMES = 1024;
  localparam int DEF_MAX_SLOTS = 64;
  localparam int W = 24;
  localparam int ACC_W = 64;
  localparam logic [1:0] CMD_LOAD_MODEL = 2'd0;
  localparam logic [1:0] CMD_LOAD_PERT = 2'd1;
  localparam logic [1:0] CMD_CORRECT = 2'd2;
  localparam logic [1:0] REG_TIME_COUNT = 2'd0;
  localparam logic [1:0] REG_SLOT_COUNT = 2'd1;
  localparam logic [1:0] REG_HALF_WINDOW = 2'd2;
  localparam logic [1:0] REG_AMP_FLOOR = 2'd3;

  typedef struct packed {
    logic       start;
    logic       clear;
    logic       accum;
    logic       div_start;
    logic       finish_div;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic low_sum;
  } sts_t;
endpackage

/* rtl/core/wrvc_if.sv */
// Valid/ready word channel interfaces
interface wrvc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [9:0]  time_index;
  logic [5:0]  slot_index;
  logic signed [23:0] value;
  modport source (output valid, command, time_index, slot_index, value, input ready);
  modport sink (input valid, command, time_index, slot_index, value, output ready);
endinterface

interface wrvc_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] corrected_velocity;
  logic        correction_applied;
  modport source (output valid, corrected_velocity, correction_applied, input ready);
  modport sink (input valid, corrected_velocity, correction_applied, output ready);
endinterface

interface wrvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/wrvc_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read
module wrvc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/wrvc_datapath.sv */
// Datapath: stores, window accumulators, serial divider and saturation
module wrvc_datapath #(
  parameter int MAX_TIMES = 1024,
  parameter int MAX_SLOTS = 64
) (
  input  logic clk,
  input  logic load_model,
  input  logic load_pert,
  input  logic [$clog2(MAX_TIMES)-1:0] t_addr,
  input  logic [$clog2(MAX_SLOTS)-1:0] s_addr,
  input  logic [$clog2(MAX_TIMES)-1:0] rt_addr,
  input  logic [$clog2(MAX_SLOTS)-1:0] rs_addr,
  input  logic signed [23:0] value,
  input  logic [23:0] amp_floor,
  input  wrvc_pkg::ctl_t ctl,
  output wrvc_pkg::sts_t sts,
  output logic signed [23:0] result,
  output logic applied
);
  import wrvc_pkg::*;
  localparam int TW = $clog2(MAX_TIMES);
  localparam int SW = $clog2(MAX_SLOTS);
  localparam int MD = 1 << (TW + SW);

  logic [23:0] m_rd, p_rd;
  wrvc_ram #(.WIDTH(24), .DEPTH(MD)) u_model (
    .clk(clk), .we(load_model), .waddr({s_addr, t_addr}), .wdata(value),
    .raddr({rs_addr, rt_addr}), .rdata(m_rd));
  wrvc_ram #(.WIDTH(24), .DEPTH(MAX_SLOTS)) u_pert (
    .clk(clk), .we(load_pert), .waddr(s_addr), .wdata(value),
    .raddr(rs_addr), .rdata(p_rd));

  localparam logic signed [63:0] PMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  logic signed [23:0] v_r;
  logic [63:0] asum_r;
  logic signed [63:0] psum_r;
  logic [23:0] mag_r;
  logic signed [23:0] pert_r;
  logic signed [48:0] prod_r;
  logic [63:0] rem_r, quo_r, dvs_r;
  logic [6:0] cnt_r;
  logic neg_r, busy_r;
  logic signed [23:0] res_r;
  logic app_r;

  logic signed [23:0] m_s;
  logic [23:0] mag;
  logic signed [64:0] psum_w;
  logic [64:0] rem_sh;
  logic signed [65:0] sum;
  always_comb begin
    m_s = m_rd;
    mag = m_s[23] ? 24'(-m_s) : m_s;
    psum_w = 65'(psum_r) + 65'(prod_r);
    rem_sh = {rem_r, quo_r[63]};
    sum = 66'(v_r) + (neg_r ? -66'(quo_r) : 66'(quo_r));
  end

  // read data lands in the cycle after accum; register magnitude, then product
  logic acc_d1_r, acc_d2_r;
  always_ff @(posedge clk) begin
    acc_d1_r <= ctl.accum;
    acc_d2_r <= acc_d1_r;
    if (ctl.start) v_r <= value;
    if (acc_d1_r) begin
      mag_r <= mag;
      pert_r <= p_rd;
    end
    if (acc_d2_r) prod_r <= $signed({1'b0, mag_r}) * pert_r;
    if (ctl.clear) begin
      asum_r <= '0;
    end else begin
      if (acc_d2_r) asum_r <= asum_r + 64'(mag_r);
    end
    if (ctl.div_start) begin
      neg_r <= psum_r[63];
      quo_r <= psum_r[63] ? 64'(-psum_r) : psum_r;
      rem_r <= '0;
      dvs_r <= asum_r;
      cnt_r <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= 65'(dvs_r)) begin
        rem_r <= 64'(rem_sh - 65'(dvs_r));
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh[63:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
      cnt_r <= cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_r <= 1'b0;
    end
    if (ctl.clear) begin
      busy_r <= 1'b0;
      res_r <= value;
      app_r <= 1'b0;
    end
    if (ctl.finish_div) begin
      app_r <= 1'b1;
      if (sum > 66'sd8388607) res_r <= 24'sd8388607;
      else if (sum < -66'sd8388608) res_r <= -24'sd8388608;
      else res_r <= sum[23:0];
    end
  end

  // saturated product accumulation, one product per cycle
  logic acc_d3_r;
  always_ff @(posedge clk) begin
    acc_d3_r <= acc_d2_r;
    if (ctl.clear) psum_r <= '0;
    else if (acc_d3_r) begin
      if (psum_w > 65'(PMAX)) psum_r <= PMAX;
      else if (psum_w < -65'(PMAX)) psum_r <= -PMAX;
      else psum_r <= psum_w[63:0];
    end
  end

  assign sts.div_done = ~busy_r & ~ctl.div_start;
  assign sts.low_sum = asum_r <= 64'(amp_floor);
  assign result = res_r;
  assign applied = app_r;
endmodule

/* rtl/core/wrvc_ctrl.sv */
// Controller: command decode and window scan sequencer
module wrvc_ctrl #(
  parameter int MAX_TIMES = 1024,
  parameter int MAX_SLOTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] command,
  input  logic [9:0] time_index,
  input  logic [5:0] slot_index,
  input  logic [10:0] time_count,
  input  logic [6:0] slot_count,
  input  logic [9:0] half_window,
  output logic out_valid,
  input  logic out_ready,
  output logic load_model,
  output logic load_pert,
  output logic [$clog2(MAX_TIMES)-1:0] rt_addr,
  output logic [$clog2(MAX_SLOTS)-1:0] rs_addr,
  output wrvc_pkg::ctl_t ctl,
  input  wrvc_pkg::sts_t sts
);
  import wrvc_pkg::*;
  localparam int TW = $clog2(MAX_TIMES);
  localparam int SW = $clog2(MAX_SLOTS);
  typedef enum logic [2:0] {IDLE, SCAN, DRAIN, DIVW, DIV, FIN, OUT} state_t;
  state_t state_r;
  logic [12:0] t_r, tend_r;
  logic [8:0] q_r, nq_r;
  logic [2:0] dr_r;
  logic acc;

  logic acc_in;
  logic [12:0] nt;
  logic [8:0] nq;
  assign acc_in = in_valid & in_ready;
  assign in_ready = (state_r == IDLE) | ((state_r == OUT) & out_ready);
  assign out_valid = state_r == OUT;
  always_comb begin
    nt = (13'(time_count) < 13'(MAX_TIMES)) ? 13'(time_count) : 13'(MAX_TIMES);
    nq = (9'(slot_count) < 9'(MAX_SLOTS)) ? 9'(slot_count) : 9'(MAX_SLOTS);
    load_model = acc_in && command == CMD_LOAD_MODEL && 13'(time_index) < 13'(MAX_TIMES)
                 && 9'(slot_index) < 9'(MAX_SLOTS);
    load_pert = acc_in && command == CMD_LOAD_PERT && 9'(slot_index) < 9'(MAX_SLOTS);
    rt_addr = t_r[TW-1:0];
    rs_addr = q_r[SW-1:0];
    ctl = '0;
    ctl.start = acc_in && command == CMD_CORRECT;
    ctl.clear = ctl.start;
    ctl.accum = acc;
    ctl.div_start = (state_r == DIVW) && dr_r == 3'd0 && !sts.low_sum;
    ctl.finish_div = (state_r == DIV) && sts.div_done;
  end
  assign acc = (state_r == SCAN) && t_r < tend_r && nq_r != 9'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      dr_r <= '0;
    end else begin
      if (state_r == OUT && out_ready) state_r <= IDLE;
      case (state_r)
        IDLE, OUT: begin
          if (ctl.start) begin
            t_r <= 13'(time_index) - 13'(half_window);
            tend_r <= 13'(time_index) + 13'(half_window);
            q_r <= '0;
            nq_r <= nq;
            if (10'(half_window) <= time_index &&
                13'(time_index) + 13'(half_window) < nt) state_r <= SCAN;
            else state_r <= OUT;
          end
        end
        SCAN: begin
          if (acc) begin
            if (q_r + 9'd1 >= nq_r) begin
              q_r <= '0;
              t_r <= t_r + 13'd1;
            end else q_r <= q_r + 9'd1;
          end else begin
            state_r <= DRAIN;
            dr_r <= 3'd5;
          end
        end
        DRAIN: state_r <= DIVW;
        DIVW: begin
          if (dr_r != 3'd0) dr_r <= dr_r - 3'd1;
          else state_r <= sts.low_sum ? OUT : DIV;
        end
        DIV: if (sts.div_done) state_r <= OUT;
        default: state_r <= IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/windowed_radon_velocity_correction_unit.sv */
// Top level of the windowed Radon velocity correction unit
// channel | dir | payload
// in_     | in  | command, time_index, slot_index, value
// out_    | out | corrected_velocity, correction_applied
// cfg_    | in  | index, data
// A correction reads the window's model store words, one per cycle, then runs a
// 64-step restoring divider; a weak window skips the divider. Edge corrections
// skip the scan and go straight to the result. Reset is synchronous, active low;
// stores are not cleared.
// A waiting result blocks the next item only until it is taken.
`include "assert_macros.svh"
module windowed_radon_velocity_correction_unit #(
  parameter int MAX_TIMES = wrvc_pkg::DEF_MAX_TIMES,
  parameter int MAX_SLOTS = wrvc_pkg::DEF_MAX_SLOTS
) (
  input logic clk,
  input logic rst_n,
  wrvc_in_if.sink in_ch,
  wrvc_out_if.source out_ch,
  wrvc_cfg_if.sink cfg_ch
);
  import wrvc_pkg::*;
  localparam int TW = $clog2(MAX_TIMES);
  localparam int SW = $clog2(MAX_SLOTS);
  logic [10:0] time_count_r;
  logic [6:0] slot_count_r;
  logic [9:0] half_window_r;
  logic [23:0] amp_floor_r;
  ctl_t ctl;
  sts_t sts;
  logic load_model, load_pert;
  logic [$clog2(MAX_TIMES)-1:0] rt_addr;
  logic [$clog2(MAX_SLOTS)-1:0] rs_addr;
  logic [TW-1:0] t_addr;
  logic [SW-1:0] s_addr;

  assign t_addr = TW'(in_ch.time_index);
  assign s_addr = SW'(in_ch.slot_index);

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_count_r <= 11'd1024;
      slot_count_r <= 7'd32;
      half_window_r <= 10'd8;
      amp_floor_r <= 24'd655;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TIME_COUNT: time_count_r <= cfg_ch.data[10:0];
        REG_SLOT_COUNT: slot_count_r <= cfg_ch.data[6:0];
        REG_HALF_WINDOW: half_window_r <= cfg_ch.data[9:0];
        REG_AMP_FLOOR: amp_floor_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  wrvc_ctrl #(.MAX_TIMES(MAX_TIMES), .MAX_SLOTS(MAX_SLOTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .command(in_ch.command), .time_index(in_ch.time_index),
    .slot_index(in_ch.slot_index), .time_count(time_count_r),
    .slot_count(slot_count_r), .half_window(half_window_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .load_model(load_model), .load_pert(load_pert),
    .rt_addr(rt_addr), .rs_addr(rs_addr), .ctl(ctl), .sts(sts));

  wrvc_datapath #(.MAX_TIMES(MAX_TIMES), .MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk(clk), .load_model(load_model), .load_pert(load_pert),
    .t_addr(t_addr), .s_addr(s_addr),
    .rt_addr(rt_addr), .rs_addr(rs_addr), .value(in_ch.value),
    .amp_floor(amp_floor_r), .ctl(ctl), .sts(sts),
    .result(out_ch.corrected_velocity), .applied(out_ch.correction_applied));

  `ASSERT_IMPL(a_load_excl, clk, rst_n, load_model, !load_pert)
  `ASSERT_NEXT(a_start_ready, clk, rst_n, ctl.start, out_ch.valid || !in_ch.ready)
  `ASSERT_IMPL(a_no_start_busy, clk, rst_n, ctl.div_start, !out_ch.valid)
endmodule

/* sim/windowed_radon_velocity_correction_unit_test.sv */
// Testbench for the windowed Radon velocity correction unit
module windowed_radon_velocity_correction_unit_test;
  import wrvc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NT = DEF_MAX_TIMES;
  localparam int NS = DEF_MAX_SLOTS;
  localparam int BAND = 8;
  localparam int STALL_LIMIT = 400000;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [23:0] velocity;
    logic               applied;
  } velocity_result_t;

  logic clk;
  logic rst_n;

  wrvc_in_if  in_if ();
  wrvc_out_if out_if ();
  wrvc_cfg_if cfg_if ();

  windowed_radon_velocity_correction_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic signed [23:0] amp_store [NS][NT];
  logic signed [23:0] pert_table [NS];
  logic [10:0] time_count_q;
  logic [6:0]  slot_count_q;
  logic [9:0]  half_window_q;
  logic [23:0] amp_floor_q;

  velocity_result_t pending_velocities [$];
  int  mismatches;
  bit  steady;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int times_in_use();
    return (time_count_q < NT) ? int'(time_count_q) : NT;
  endfunction

  function automatic int slots_in_use();
    return (slot_count_q < NS) ? int'(slot_count_q) : NS;
  endfunction

  function automatic velocity_result_t predict_velocity(logic [9:0] ti,
                                                       logic signed [23:0] v);
    velocity_result_t r;
    longint asum;
    longint psum;
    longint mag;
    longint prod;
    longint res;
    int nt;
    int nq;
    int h;
    nt = times_in_use();
    nq = slots_in_use();
    h = int'(half_window_q);
    res = longint'(v);
    r.applied = 1'b0;
    if (int'(ti) >= h && int'(ti) + h < nt) begin
      asum = 0;
      psum = 0;
      for (int tw = int'(ti) - h; tw < int'(ti) + h; tw++) begin
        for (int q = 0; q < nq; q++) begin
          mag = longint'(amp_store[q][tw]);
          if (mag < 0) mag = -mag;
          asum += mag;
          prod = mag * longint'(pert_table[q]);
          if (prod > 0 && psum > SUM_MAX - prod) psum = SUM_MAX;
          else if (prod < 0 && psum < -SUM_MAX - prod) psum = -SUM_MAX;
          else psum += prod;
        end
      end
      if (asum > longint'(amp_floor_q)) begin
        res += psum / asum;
        r.applied = 1'b1;
      end
    end
    if (res > 64'sd8388607) res = 64'sd8388607;
    if (res < -64'sd8388608) res = -64'sd8388608;
    r.velocity = res[23:0];
    return r;
  endfunction

  task automatic idle_gap();
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic [1:0] cmd, input logic [9:0] ti,
                           input logic [5:0] si, input logic signed [23:0] val);
    idle_gap();
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.time_index <= ti;
    in_if.slot_index <= si;
    in_if.value      <= val;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    case (cmd)
      CMD_LOAD_MODEL: amp_store[si][ti] = val;
      CMD_LOAD_PERT:  pert_table[si] = val;
      CMD_CORRECT:    pending_velocities.push_back(predict_velocity(ti, val));
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_velocities.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      cfg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(negedge clk); while (!cfg_if.ready);
    @(posedge clk);
    case (idx)
      REG_TIME_COUNT:  time_count_q = data[10:0];
      REG_SLOT_COUNT:  slot_count_q = data[6:0];
      REG_HALF_WINDOW: half_window_q = data[9:0];
      REG_AMP_FLOOR:   amp_floor_q = data;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(input logic [23:0] tc, input logic [23:0] sc,
                           input logic [23:0] hw, input logic [23:0] fl);
    wait_idle();
    write_reg(REG_TIME_COUNT, tc);
    write_reg(REG_SLOT_COUNT, sc);
    write_reg(REG_HALF_WINDOW, hw);
    write_reg(REG_AMP_FLOOR, fl);
  endtask

  function automatic logic signed [23:0] rand_amplitude();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom());
      default: return 24'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  // interior windows stay inside the loaded band; others sit on an edge, but a zero half window picks any time
  function automatic logic [9:0] pick_time();
    int nt;
    int h;
    int hi;
    nt = times_in_use();
    h = int'(half_window_q);
    hi = (BAND - h < nt - h - 1) ? BAND - h : nt - h - 1;
    if (h == 0) return 10'($urandom());
    if (h <= hi && $urandom_range(0, 9) < 7) return 10'($urandom_range(h, hi));
    if (nt - h > 0 && nt - h <= 1023 && $urandom_range(0, 1) == 0)
      return 10'($urandom_range(nt - h, 1023));
    return 10'($urandom_range(0, h - 1));
  endfunction

  task automatic test_store_fill();
    for (int s = 0; s < NS; s++) send_word(CMD_LOAD_PERT, 10'($urandom()), 6'(s),
                                          24'($urandom()));
    for (int s = 0; s < NS; s++) begin
      steady = (s % 4) == 0;
      for (int t = 0; t < BAND; t++)
        send_word(CMD_LOAD_MODEL, 10'(t), 6'(s), rand_amplitude());
    end
    steady = 1'b0;
  endtask

  task automatic test_edges_and_extremes();
    configure(24'd9, 24'd32, 24'd4, 24'd655);
    send_word(CMD_CORRECT, 10'd0, 6'd0, 24'sh123456);
    send_word(CMD_CORRECT, 10'd3, 6'd63, 24'sh7FFFFF);
    send_word(CMD_CORRECT, 10'd4, 6'd0, 24'sh800000);
    send_word(CMD_CORRECT, 10'd5, 6'd0, 24'sd0);
    send_word(CMD_CORRECT, 10'd1023, 6'd0, -24'sd1);
    send_word(CMD_CORRECT, 10'd4, 6'd0, 24'sh7FFFFF);
    send_word(CMD_UNUSED, 10'd1023, 6'd63, 24'sh7FFFFF);
    send_word(CMD_UNUSED, 10'd0, 6'd0, 24'sh800000);
  endtask

  task automatic test_weak_window();
    configure(24'd1024, 24'd1, 24'd1, 24'd655);
    send_word(CMD_LOAD_MODEL, 10'd2, 6'd0, 24'sd0);
    send_word(CMD_CORRECT, 10'd3, 6'd0, 24'sh000155);
    send_word(CMD_LOAD_MODEL, 10'd2, 6'd0, -24'sd655);
    send_word(CMD_CORRECT, 10'd3, 6'd0, -24'sh000155);
    send_word(CMD_LOAD_MODEL, 10'd2, 6'd0, -24'sd656);
    send_word(CMD_CORRECT, 10'd3, 6'd0, 24'sh000155);
  endtask

  task automatic test_saturation();
    send_word(CMD_LOAD_MODEL, 10'd4, 6'd0, -24'sh100000);
    send_word(CMD_LOAD_PERT, 10'd0, 6'd0, 24'sh7FFFFF);
    send_word(CMD_CORRECT, 10'd5, 6'd0, 24'sh7FFFFF);
    send_word(CMD_CORRECT, 10'd5, 6'd0, 24'sd0);
    send_word(CMD_LOAD_PERT, 10'd0, 6'd0, 24'sh800000);
    send_word(CMD_CORRECT, 10'd5, 6'd0, 24'sh800000);
    send_word(CMD_LOAD_PERT, 10'd0, 6'd0, 24'($urandom()));
  endtask

  task automatic run_random(input int count, input int max_corrections);
    int corrections;
    int pick;
    corrections = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) steady = $urandom_range(0, 3) == 0;
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_word(CMD_LOAD_MODEL, 10'($urandom()), 6'($urandom()), rand_amplitude());
      else if (pick < 50)
        send_word(CMD_LOAD_PERT, 10'($urandom()), 6'($urandom()), 24'($urandom()));
      else if (pick < 95 && corrections < max_corrections) begin
        send_word(CMD_CORRECT, pick_time(), 6'($urandom()), 24'($urandom()));
        corrections++;
      end else
        send_word(CMD_UNUSED, 10'($urandom()), 6'($urandom()), 24'($urandom()));
    end
    steady = 1'b0;
  endtask

  task automatic test_register_sweep();
    configure(24'd1024, 24'd64, 24'd2, 24'd655);
    run_random(80, 80);
    configure(24'hFFF800 | 24'd16, 24'd1, 24'd1, 24'd0);
    run_random(50, 50);
    configure(24'd2047, 24'd127, 24'd0, 24'd0);
    run_random(30, 30);
    configure(24'd0, 24'd0, 24'd3, 24'd0);
    run_random(20, 20);
    configure(24'd1, 24'd5, 24'd0, 24'hFFFFFF);
    run_random(20, 20);
    configure(24'd300, 24'd6, 24'd3, 24'($urandom()));
    run_random(60, 60);
    configure(24'd1024, 24'd64, 24'd512, 24'd16777215);
    send_word(CMD_CORRECT, 10'd512, 6'd0, 24'sh000100);
    configure(24'd1024, 24'd64, 24'd512, 24'd1);
    send_word(CMD_CORRECT, 10'd512, 6'd0, 24'sh7FFF00);
    send_word(CMD_CORRECT, 10'd511, 6'd0, 24'sh000100);
    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
    run_random(20, 20);
    configure(24'd700, 24'd40, 24'd2, 24'($urandom_range(0, 20000)));
    run_random(80, 80);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      int stall;
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk); while (!out_if.valid);
      if (pending_velocities.size() == 0) begin
        $error("unexpected result: corrected_velocity %0d", out_if.corrected_velocity);
        mismatches++;
      end else begin
        velocity_result_t exp_r;
        exp_r = pending_velocities.pop_front();
        if (out_if.corrected_velocity !== exp_r.velocity) begin
          $error("corrected_velocity expected %0d actual %0d", exp_r.velocity,
                 out_if.corrected_velocity);
          mismatches++;
        end
        if (out_if.correction_applied !== exp_r.applied) begin
          $error("correction_applied expected %0d actual %0d", exp_r.applied,
                 out_if.correction_applied);
          mismatches++;
        end
      end
      @(posedge clk);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(negedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready) || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("windowed_radon_velocity_correction_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD_MODEL;
    in_if.time_index = '0;
    in_if.slot_index = '0;
    in_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TIME_COUNT;
    cfg_if.data = '0;
    time_count_q = 11'd1024;
    slot_count_q = 7'd32;
    half_window_q = 10'd8;
    amp_floor_q = 24'd655;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_store_fill();
    test_edges_and_extremes();
    test_weak_window();
    test_saturation();
    test_register_sweep();
    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_velocities.size() == 0)
      $display("windowed_radon_velocity_correction_unit regression: pass");
    else
      $display("windowed_radon_velocity_correction_unit regression: fail");
    $finish;
  end
endmodule
